>>> hw/rtl/qtp_pkg.sv
package qtp_pkg;

	localparam logic OP_POLL = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [0:0] REG_SCALE_NUM = 1'b0;
	localparam logic [0:0] REG_WINDOW = 1'b1;

	localparam logic [15:0] SCALE_NUM_RESET = 16'd256;
	localparam logic [31:0] WINDOW_RESET = 32'd59736;

	// rounding division is a shift, so the denominator stays a power of two
	localparam int SCALE_DENOMINATOR = 256;

	// datapath commands
	typedef struct packed {
		logic complete;    // finish pending steps on both axes
		logic scale;       // compute scaled value for current axis
		logic round_div;   // settle rounding quotient and residue
		logic sched;       // load schedule for current axis
		logic capture;     // latch request fields at accept
		logic div_start;   // start shared divider
		logic div_sel_due; // divider operands: 1 due, 0 window
		logic apply;       // apply due count on current axis
		logic axis;        // current axis
		logic out_load;    // capture result
	} qtp_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic need_div;    // current axis has due work needing division
		logic trans_zero;  // scaled transition count is zero
	} qtp_sts_t;

endpackage

>>> hw/rtl/qtp_divider.sv
module qtp_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        busy,
	output logic [63:0] quotient
);

	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] den_q;
	logic [6:0]  cnt_q;
	logic [64:0] trial;

	assign trial = {rem_q, quo_q[63]} - {1'b0, den_q};
	assign busy = (cnt_q != 7'd0);
	assign quotient = quo_q;

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 7'd0;
		end else if (start) begin
			cnt_q <= 7'd64;
		end else if (busy) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 64'd0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy) begin
			if (!trial[64] && !(rem_q[63])) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else if (rem_q[63]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

endmodule

>>> hw/rtl/qtp_datapath.sv
module qtp_datapath #(
	parameter int MAX_TRANSITIONS = 1023,
	parameter int RES_W = 18,
	parameter int STEP_W = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  qtp_pkg::qtp_cmd_t  cmd,
	output qtp_pkg::qtp_sts_t  sts,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_idx,
	input  logic [31:0]        cfg_data,
	input  logic signed [15:0] delta_x,
	input  logic signed [15:0] delta_y,
	input  logic [63:0]        timestamp,
	input  logic               fire_pressed,
	output logic [1:0]         x_phase,
	output logic [1:0]         y_phase,
	output logic               x_moving_negative,
	output logic               y_moving_positive,
	output logic               fire_released
);

	localparam int HALF = qtp_pkg::SCALE_DENOMINATOR / 2;
	localparam int SH = $clog2(qtp_pkg::SCALE_DENOMINATOR);
	localparam int SC_W = 34 + RES_W;

	logic [15:0] scale_num_q;
	logic [31:0] window_q;

	logic [1:0]              phase_q [2];
	logic [1:0]              dir_q [2];   // 01 positive, 11 negative, 00 none
	logic [STEP_W-1:0]       left_q [2];
	logic [63:0]             next_q [2];
	logic [63:0]             iv_q [2];
	logic signed [RES_W-1:0] res_q [2];

	logic signed [SC_W-1:0]  scaled_q;
	logic signed [SC_W-1:0]  trans_q;
	logic [STEP_W-1:0]       mag_q;
	logic                    neg_q;

	// request fields held for the whole request
	logic signed [15:0]      dx_q, dy_q;
	logic [63:0]             ts_q;
	logic                    fire_q;

	logic [1:0] out_xp_q, out_yp_q;
	logic out_xn_q, out_yp_dir_q, out_fr_q;

	logic                    a;
	logic signed [16:0]      dneg;
	logic signed [16:0]      dcl;
	logic signed [33:0]      prod;
	logic signed [SC_W-1:0]  adj;
	logic signed [SC_W-1:0]  tr;
	logic [63:0]             div_a, div_b, div_q;
	logic                    div_busy;
	logic [63:0]             iv_eff;
	logic [63:0]             due;
	logic [STEP_W-1:0]       due_n;

	assign a = cmd.axis;

	always_comb begin
		dneg = a ? -$signed({dy_q[15], dy_q}) : -$signed({dx_q[15], dx_q});
		dcl = dneg;
		if (dneg > 17'sd32767) dcl = 17'sd32767;
		prod = dcl * $signed({1'b0, scale_num_q});
		adj = scaled_q + (scaled_q < 0 ? -SC_W'(HALF) : SC_W'(HALF));
		// truncating divide by a power of two
		tr = (adj < 0) ? -((-adj) >>> SH) : (adj >>> SH);
	end

	assign iv_eff = (iv_q[a] == 64'd0) ? 64'd1 : iv_q[a];
	assign div_a = cmd.div_sel_due ? (ts_q - next_q[a]) : {32'd0, window_q};
	assign div_b = cmd.div_sel_due ? iv_eff : {{(64-STEP_W){1'b0}}, mag_q};

	qtp_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(div_a), .divisor(div_b), .busy(div_busy), .quotient(div_q)
	);

	assign due = div_q + 64'd1;
	assign due_n = (due > {{(64-STEP_W){1'b0}}, left_q[a]}) ? left_q[a] : due[STEP_W-1:0];

	assign sts.div_busy = div_busy;
	assign sts.need_div = (left_q[a] != '0) && (ts_q >= next_q[a]);
	assign sts.trans_zero = (trans_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_num_q <= qtp_pkg::SCALE_NUM_RESET;
			window_q <= qtp_pkg::WINDOW_RESET;
			for (int i = 0; i < 2; i++) begin
				phase_q[i] <= 2'd0;
				dir_q[i] <= 2'd0;
				left_q[i] <= '0;
				next_q[i] <= 64'd0;
				iv_q[i] <= 64'd1;
				res_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				if (cfg_idx == qtp_pkg::REG_SCALE_NUM) scale_num_q <= cfg_data[15:0];
				else window_q <= cfg_data;
			end
			if (cmd.complete) begin
				for (int i = 0; i < 2; i++) begin
					if (dir_q[i] == 2'b01)
						phase_q[i] <= phase_q[i] + left_q[i][1:0];
					else if (dir_q[i] == 2'b11)
						phase_q[i] <= phase_q[i] - left_q[i][1:0];
					left_q[i] <= '0;
					next_q[i] <= 64'd0;
					iv_q[i] <= 64'd1;
				end
			end
			if (cmd.round_div) begin
				res_q[a] <= RES_W'(scaled_q - (tr <<< SH));
			end
			if (cmd.sched) begin
				dir_q[a] <= neg_q ? 2'b11 : 2'b01;
				left_q[a] <= mag_q;
				iv_q[a] <= (div_q == 64'd0) ? 64'd1 : div_q;
				next_q[a] <= (div_q == 64'd0) ? 64'd1 : div_q;
			end
			if (cmd.apply) begin
				if (dir_q[a] == 2'b01) phase_q[a] <= phase_q[a] + due_n[1:0];
				else if (dir_q[a] == 2'b11) phase_q[a] <= phase_q[a] - due_n[1:0];
				left_q[a] <= left_q[a] - due_n;
				next_q[a] <= next_q[a] + iv_eff * {{(64-STEP_W){1'b0}}, due_n};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			dx_q <= delta_x;
			dy_q <= delta_y;
			ts_q <= timestamp;
			fire_q <= fire_pressed;
		end
		if (cmd.scale) begin
			scaled_q <= SC_W'(prod) + SC_W'(res_q[a]);
		end
		if (cmd.round_div) begin
			trans_q <= tr;
			if (tr > SC_W'(MAX_TRANSITIONS)) begin
				mag_q <= STEP_W'(MAX_TRANSITIONS);
			end else if (tr < -SC_W'(MAX_TRANSITIONS)) begin
				mag_q <= STEP_W'(MAX_TRANSITIONS);
			end else begin
				mag_q <= (tr < 0) ? STEP_W'(-tr) : STEP_W'(tr);
			end
			neg_q <= (tr < 0);
		end
		if (cmd.out_load) begin
			out_xp_q <= phase_q[0];
			out_yp_q <= phase_q[1];
			out_xn_q <= (dir_q[0] == 2'b11);
			out_yp_dir_q <= (dir_q[1] == 2'b01);
			out_fr_q <= !fire_q;
		end
	end

	assign x_phase = out_xp_q;
	assign y_phase = out_yp_q;
	assign x_moving_negative = out_xn_q;
	assign y_moving_positive = out_yp_dir_q;
	assign fire_released = out_fr_q;

endmodule

>>> hw/rtl/qtp_ctrl.sv
module qtp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              operation,
	output logic              out_valid,
	input  logic              out_ready,
	input  qtp_pkg::qtp_sts_t sts,
	output qtp_pkg::qtp_cmd_t cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SCALE  = 4'd1;
	localparam logic [3:0] S_ROUND  = 4'd2;
	localparam logic [3:0] S_CHK    = 4'd3;
	localparam logic [3:0] S_WDIV   = 4'd4;
	localparam logic [3:0] S_SCHED  = 4'd5;
	localparam logic [3:0] S_DUE    = 4'd6;
	localparam logic [3:0] S_DWAIT  = 4'd7;
	localparam logic [3:0] S_APPLY  = 4'd8;
	localparam logic [3:0] S_OUT    = 4'd9;
	localparam logic [3:0] S_DSTART = 4'd10;
	localparam logic [3:0] S_WSTART = 4'd11;

	logic [3:0] state_q;
	logic       axis_q;
	logic       out_valid_q;

	assign in_ready = (state_q == S_IDLE) && !(out_valid_q && !out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.axis = axis_q;
		case (state_q)
			S_IDLE: begin
				cmd.capture = in_valid && in_ready;
				cmd.complete = in_valid && in_ready && (operation == qtp_pkg::OP_POLL);
			end
			S_SCALE:  cmd.scale = 1'b1;
			S_ROUND:  cmd.round_div = 1'b1;
			S_WSTART: cmd.div_start = 1'b1;
			// a zero transition count leaves the axis schedule untouched
			S_SCHED:  cmd.sched = !sts.trans_zero;
			S_DSTART: begin
				cmd.div_start = 1'b1;
				cmd.div_sel_due = 1'b1;
			end
			S_DWAIT:  cmd.div_sel_due = 1'b1;
			S_APPLY: begin
				cmd.apply = sts.need_div;
				cmd.div_sel_due = 1'b1;
			end
			S_OUT:    cmd.out_load = !(out_valid_q && !out_ready);
			default:  cmd.complete = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			axis_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && !(out_valid_q && !out_ready)) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					axis_q <= 1'b0;
					if (in_valid && in_ready)
						state_q <= (operation == qtp_pkg::OP_POLL) ? S_SCALE : S_DUE;
				end
				S_SCALE: state_q <= S_ROUND;
				S_ROUND: state_q <= S_CHK;
				S_CHK:   state_q <= sts.trans_zero ? S_SCHED : S_WSTART;
				S_WSTART: state_q <= S_WDIV;
				S_WDIV:  if (!sts.div_busy) state_q <= S_SCHED;
				S_SCHED: begin
					axis_q <= ~axis_q;
					state_q <= axis_q ? S_IDLE : S_SCALE;
				end
				S_DUE: state_q <= sts.need_div ? S_DSTART : S_APPLY;
				S_DSTART: state_q <= S_DWAIT;
				S_DWAIT: if (!sts.div_busy) state_q <= S_APPLY;
				S_APPLY: begin
					axis_q <= ~axis_q;
					state_q <= axis_q ? S_OUT : S_DUE;
				end
				S_OUT: begin
					if (!(out_valid_q && !out_ready))
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> hw/rtl/quadrature_transition_pacer_top.sv
// quadrature transition pacer: a poll request (operation 0) finishes any
// pending steps on both axes, then scales the negated, clamped deltas by
// scale_numerator over SCALE_DENOMINATOR with a carried residue, rounds half
// away from zero, clamps to MAX_TRANSITIONS and spreads the transitions over
// window_duration ticks; it returns nothing, and the window division runs
// only on an axis with motion.
// a read request (operation 1) applies the steps due at its timestamp and
// returns one result, using the single bit-per-cycle 64-bit divider
// shared by both axes. the user must write configuration registers only
// while the block is idle; the block itself does not enforce this.
module quadrature_transition_pacer_top #(
	parameter int MAX_TRANSITIONS = 1023
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               operation,
	input  logic signed [15:0] delta_x,
	input  logic signed [15:0] delta_y,
	input  logic [63:0]        timestamp,
	input  logic               fire_pressed,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         x_phase,
	output logic [1:0]         y_phase,
	output logic               x_moving_negative,
	output logic               y_moving_positive,
	output logic               fire_released
);

	// residue width and step counter width follow the constants
	localparam int RES_W = $clog2(qtp_pkg::SCALE_DENOMINATOR) + 2;
	localparam int STEP_W = $clog2(MAX_TRANSITIONS + 1) + 1;

	qtp_pkg::qtp_cmd_t cmd;
	qtp_pkg::qtp_sts_t sts;

	// sequencer: one request at a time
	qtp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .operation(operation),
		.out_valid(out_valid), .out_ready(out_ready),
		.sts(sts), .cmd(cmd)
	);

	// per-axis state, scaling and the shared divider
	qtp_datapath #(
		.MAX_TRANSITIONS(MAX_TRANSITIONS),
		.RES_W(RES_W),
		.STEP_W(STEP_W)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
		.delta_x(delta_x), .delta_y(delta_y), .timestamp(timestamp),
		.fire_pressed(fire_pressed),
		.x_phase(x_phase), .y_phase(y_phase),
		.x_moving_negative(x_moving_negative),
		.y_moving_positive(y_moving_positive),
		.fire_released(fire_released)
	);

endmodule

>>> hw/rtl/qtp_checker.sv
module qtp_port_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic operation,
	input logic out_valid,
	input logic out_ready,
	input logic fire_released
);

	// result held while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(fire_released))
		else $error("result dropped while stalled");

	// a poll accepted while no result is pending produces no result next cycle
	a_poll_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !operation && !out_valid |=> !out_valid)
		else $error("poll produced a result");

	// no new request while a previous one is at work
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

endmodule

bind quadrature_transition_pacer_top qtp_port_checker u_qtp_port_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.operation(operation), .out_valid(out_valid), .out_ready(out_ready),
	.fire_released(fire_released)
);

>>> tb/qtp_checker.sv
`timescale 1ns / 1ps

module qtp_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               operation,
	input  logic signed [15:0] delta_x,
	input  logic signed [15:0] delta_y,
	input  logic [63:0]        timestamp,
	input  logic               fire_pressed,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [1:0]         x_phase,
	input  logic [1:0]         y_phase,
	input  logic               x_moving_negative,
	input  logic               y_moving_positive,
	input  logic               fire_released,
	output int                 fail_count,
	output int                 reads_waiting,
	output int                 reads_checked
);

	localparam longint SCALE_DEN = 256;
	localparam longint TRANS_MAX = 1023;

	typedef struct packed {
		logic [1:0] x_phase;
		logic [1:0] y_phase;
		logic       x_neg;
		logic       y_pos;
		logic       fire_rel;
	} port_state_t;

	port_state_t read_q[$];

	logic [15:0] num_q;
	logic [31:0] win_q;
	logic [1:0]  phase_q[2];
	int          dir_q[2];
	int unsigned steps_q[2];
	logic [63:0] due_q[2];
	logic [63:0] ival_q[2];
	longint      resid_q[2];

	function automatic void rotate(int a, logic [63:0] count);
		if (dir_q[a] > 0)
			phase_q[a] = phase_q[a] + count[1:0];
		else if (dir_q[a] < 0)
			phase_q[a] = phase_q[a] - count[1:0];
	endfunction

	function automatic void finish_axis(int a);
		if (steps_q[a] != 0)
			rotate(a, 64'(steps_q[a]));
		steps_q[a] = 0;
		due_q[a] = '0;
		ival_q[a] = 64'd1;
	endfunction

	function automatic void plan_axis(int a, logic signed [15:0] raw);
		longint d, scaled, trans;
		logic [63:0] mag, iv;
		d = -longint'(raw);
		if (d > 32767)
			d = 32767;
		scaled = d * longint'(num_q) + resid_q[a];
		if (scaled < 0)
			trans = (scaled - SCALE_DEN / 2) / SCALE_DEN;
		else
			trans = (scaled + SCALE_DEN / 2) / SCALE_DEN;
		resid_q[a] = scaled - trans * SCALE_DEN;
		if (trans < -TRANS_MAX)
			trans = -TRANS_MAX;
		if (trans > TRANS_MAX)
			trans = TRANS_MAX;
		if (trans == 0)
			return;
		dir_q[a] = (trans < 0) ? -1 : 1;
		mag = 64'((trans < 0) ? -trans : trans);
		steps_q[a] = int'(mag);
		iv = {32'd0, win_q} / mag;
		if (iv == 0)
			iv = 64'd1;
		ival_q[a] = iv;
		due_q[a] = iv;
	endfunction

	function automatic void catch_up(int a, logic [63:0] now);
		logic [63:0] n;
		if (steps_q[a] == 0 || now < due_q[a])
			return;
		n = 64'd1 + (now - due_q[a]) / ival_q[a];
		if (n > 64'(steps_q[a]))
			n = 64'(steps_q[a]);
		rotate(a, n);
		steps_q[a] = steps_q[a] - int'(n);
		due_q[a] = due_q[a] + ival_q[a] * n;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		port_state_t want;
		if (!arst_n) begin
			num_q <= qtp_pkg::SCALE_NUM_RESET;
			win_q <= qtp_pkg::WINDOW_RESET;
			for (int a = 0; a < 2; a++) begin
				phase_q[a] = '0;
				dir_q[a] = 0;
				steps_q[a] = 0;
				due_q[a] = '0;
				ival_q[a] = 64'd1;
				resid_q[a] = 0;
			end
			read_q.delete();
			fail_count <= 0;
			reads_waiting <= 0;
			reads_checked <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == qtp_pkg::REG_SCALE_NUM)
					num_q <= cfg_data[15:0];
				else if (cfg_index == qtp_pkg::REG_WINDOW)
					win_q <= cfg_data;
			end
			if (out_valid && out_ready) begin
				if (read_q.size() == 0) begin
					$error("result with no read request waiting");
					fail_count <= fail_count + 1;
				end else begin
					want = read_q.pop_front();
					if (x_phase !== want.x_phase ||
						y_phase !== want.y_phase ||
						x_moving_negative !== want.x_neg ||
						y_moving_positive !== want.y_pos ||
						fire_released !== want.fire_rel)
						fail_count <= fail_count + 1;
					if (x_phase !== want.x_phase)
						$error("x_phase exp %0d got %0d", want.x_phase, x_phase);
					if (y_phase !== want.y_phase)
						$error("y_phase exp %0d got %0d", want.y_phase, y_phase);
					if (x_moving_negative !== want.x_neg)
						$error("x_moving_negative exp %0d got %0d", want.x_neg,
							x_moving_negative);
					if (y_moving_positive !== want.y_pos)
						$error("y_moving_positive exp %0d got %0d", want.y_pos,
							y_moving_positive);
					if (fire_released !== want.fire_rel)
						$error("fire_released exp %0d got %0d", want.fire_rel,
							fire_released);
					reads_checked <= reads_checked + 1;
				end
			end
			if (in_valid && in_ready) begin
				if (operation == qtp_pkg::OP_POLL) begin
					finish_axis(0);
					finish_axis(1);
					plan_axis(0, delta_x);
					plan_axis(1, delta_y);
				end else begin
					catch_up(0, timestamp);
					catch_up(1, timestamp);
					want.x_phase = phase_q[0];
					want.y_phase = phase_q[1];
					want.x_neg = dir_q[0] < 0;
					want.y_pos = dir_q[1] > 0;
					want.fire_rel = !fire_pressed;
					read_q.push_back(want);
				end
			end
			reads_waiting <= read_q.size();
		end
	end

endmodule

>>> tb/tb_quadrature_transition_pacer_top.sv
`timescale 1ns / 1ps

module tb_quadrature_transition_pacer_top;

	localparam int SETTLE_CYCLES = 200;     // covers the slowest poll with no result
	localparam int CYCLE_LIMIT = 1500000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [0:0]         cfg_index = qtp_pkg::REG_SCALE_NUM;
	logic [31:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               operation = qtp_pkg::OP_POLL;
	logic signed [15:0] delta_x = '0;
	logic signed [15:0] delta_y = '0;
	logic [63:0]        timestamp = '0;
	logic               fire_pressed = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         x_phase;
	logic [1:0]         y_phase;
	logic               x_moving_negative;
	logic               y_moving_positive;
	logic               fire_released;

	int fail_count, reads_waiting, reads_checked;
	int cycle_count = 0;
	int burst_left = 0;
	int poll_count = 0, read_count = 0, setting_count = 0;
	logic [31:0] cur_window = qtp_pkg::WINDOW_RESET;
	logic [63:0] clock_now;

	always #10 clk = ~clk;

	quadrature_transition_pacer_top dut (.*);

	qtp_checker checker_i (.*);

	// give up if the block stops making progress
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver: switches between always ready, light stalls and heavy stalls
	always @(posedge clk) begin
		int mode_left, mode;
		if (mode_left <= 0) begin
			mode = $urandom_range(0, 2);
			mode_left = $urandom_range(20, 400);
		end
		mode_left--;
		case (mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			default: out_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// one request; bursts of random length with idle gaps between them
	task automatic send_request(logic op, logic signed [15:0] dx, logic signed [15:0] dy,
		logic [63:0] ts, logic fire);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 25)) @(posedge clk);
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		in_valid <= 1'b1;
		operation <= op;
		delta_x <= dx;
		delta_y <= dy;
		timestamp <= ts;
		fire_pressed <= fire;
		do @(posedge clk); while (!in_ready);
		if (op == qtp_pkg::OP_POLL)
			poll_count++;
		else
			read_count++;
	endtask

	// hold requests until every result is back and the block has gone quiet
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (reads_waiting != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_regs(logic [15:0] num, logic [31:0] win);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= qtp_pkg::REG_SCALE_NUM;
		cfg_data <= {16'd0, num};
		@(posedge clk);
		cfg_index <= qtp_pkg::REG_WINDOW;
		cfg_data <= win;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_window = win;
		setting_count++;
	endtask

	function automatic logic signed [15:0] pick_delta();
		case ($urandom_range(0, 9))
			0, 1, 2: return 16'($signed($urandom_range(0, 64)) - 32);
			3, 4: return 16'($signed($urandom_range(0, 4000)) - 2000);
			5: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
			default: return 16'($urandom);
		endcase
	endfunction

	// a poll followed by reads whose clock runs through the window
	task automatic motion_burst();
		int n;
		logic [63:0] hop;
		send_request(qtp_pkg::OP_POLL, pick_delta(), pick_delta(), 64'($urandom),
			$urandom_range(0, 1));
		clock_now = '0;
		hop = {32'd0, cur_window} / 64'($urandom_range(1, 40)) + 64'd1;
		n = $urandom_range(1, 6);
		repeat (n) begin
			clock_now = clock_now + 64'($urandom) % hop;
			send_request(qtp_pkg::OP_READ, 16'($urandom), 16'($urandom), clock_now,
				$urandom_range(0, 1));
		end
	endtask

	task automatic noise_request();
		if ($urandom_range(0, 1))
			send_request(qtp_pkg::OP_READ, 16'($urandom), 16'($urandom),
				{$urandom, $urandom}, $urandom_range(0, 1));
		else
			send_request(qtp_pkg::OP_POLL, 16'($urandom), 16'($urandom),
				{$urandom, $urandom}, $urandom_range(0, 1));
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset registers, extremes of deltas and timestamps
		send_request(qtp_pkg::OP_READ, 16'sh0000, 16'sh0000, 64'd0, 1'b1);     // idle read
		send_request(qtp_pkg::OP_POLL, 16'sh8000, 16'sh7fff, 64'd0, 1'b0);     // clamp on negate
		send_request(qtp_pkg::OP_READ, 16'sh0000, 16'sh0000, 64'd57, 1'b0);    // early read
		send_request(qtp_pkg::OP_READ, 16'sh0000, 16'sh0000, 64'd59736, 1'b1); // all due, capped
		send_request(qtp_pkg::OP_POLL, 16'sh0080, -16'sh0080, 64'd0, 1'b0);    // exact multiples, no rounding
		send_request(qtp_pkg::OP_POLL, 16'sh0000, 16'sh0000, 64'd0, 1'b0);     // zero keeps dir
		send_request(qtp_pkg::OP_READ, 16'sh0000, 16'sh0000, 64'hffff_ffff_ffff_ffff, 1'b0);
		send_request(qtp_pkg::OP_POLL, 16'sh0001, -16'sh0001, 64'd0, 1'b1);
		send_request(qtp_pkg::OP_POLL, 16'sh0001, -16'sh0001, 64'd0, 1'b1);
		send_request(qtp_pkg::OP_READ, 16'sh7fff, 16'sh8000, 64'd30000, 1'b1);

		set_regs(16'd65535, 32'hffff_ffff);                             // widest settings
		send_request(qtp_pkg::OP_POLL, 16'sh8000, 16'sh8000, 64'd0, 1'b0);     // clamp past max
		send_request(qtp_pkg::OP_READ, 16'sh0000, 16'sh0000, 64'd4198534, 1'b0);
		send_request(qtp_pkg::OP_READ, 16'sh0000, 16'sh0000, 64'hffff_ffff_ffff_fff0, 1'b1);
		set_regs(16'd1, 32'd0);                                         // zero window
		send_request(qtp_pkg::OP_POLL, -16'sh0080, 16'sh0080, 64'd0, 1'b0);
		send_request(qtp_pkg::OP_POLL, -16'sh0080, 16'sh0080, 64'd0, 1'b0);    // residue carries
		send_request(qtp_pkg::OP_READ, 16'sh0000, 16'sh0000, 64'd0, 1'b1);
		send_request(qtp_pkg::OP_READ, 16'sh0000, 16'sh0000, 64'd1, 1'b0);
		set_regs(16'd0, 32'd1);                                         // zero numerator
		send_request(qtp_pkg::OP_POLL, 16'sh7fff, 16'sh8000, 64'd0, 1'b0);
		send_request(qtp_pkg::OP_READ, 16'sh0000, 16'sh0000, 64'd5, 1'b1);

		// random phases over several register settings
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: set_regs(qtp_pkg::SCALE_NUM_RESET, qtp_pkg::WINDOW_RESET);
				1: set_regs(16'd1, 32'd1);
				2: set_regs(16'd65535, 32'hffff_ffff);
				3: set_regs(16'($urandom_range(1, 2048)), $urandom_range(1, 200000));
				default: set_regs(16'($urandom), $urandom);
			endcase
			while (poll_count + read_count < 60 + 200 * (phase + 1)) begin
				if ($urandom_range(0, 9) == 0)
					noise_request();
				else
					motion_burst();
				if (phase == 2 && read_count % 97 == 0)
					drain();                                            // let the block run dry
			end
		end

		drain();
		$display("sent %0d polls and %0d reads across %0d register settings",
			poll_count, read_count, setting_count);
		$display("compared %0d results", reads_checked);
		if (fail_count == 0 && reads_waiting == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/qtp_pkg.sv
hw/rtl/qtp_divider.sv
hw/rtl/qtp_datapath.sv
hw/rtl/qtp_ctrl.sv
hw/rtl/quadrature_transition_pacer_top.sv
hw/rtl/qtp_checker.sv
tb/qtp_checker.sv
tb/tb_quadrature_transition_pacer_top.sv
